// File: sv/tmpi_pkg.sv
// shared constants and command/status types for the transition matrix product unit
// no dependencies
package tmpi_pkg;

    localparam int NUM_STATES_DEF = 4;
    localparam int REG_ADDR_W     = 4;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [31:0] Q30_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q30_MIN = 32'sh8000_0000;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DIRECTION  = 2'd0;
    localparam logic [1:0] REG_PRED_TIME  = 2'd1;
    localparam logic [1:0] REG_STATES     = 2'd2;

    typedef struct packed {
        logic inc_we;
        logic inc_clear;
        logic p_clear;
        logic ts_load;
        logic sum_en;
        logic sum_first;
        logic sum_last;
        logic mac_en;
        logic mac_first;
        logic mac_last;
        logic emit_rd;
        logic emit_ld;
        logic emit_last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// File: sv/tmpi_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module tmpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/tmpi_ctrl.sv
// controller: configuration registers, sequencing of row sums, products and emission
// depends on tmpi_pkg
module tmpi_ctrl
    import tmpi_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF,
    localparam int SW = $clog2(NUM_STATES),
    localparam int CW = $clog2(NUM_STATES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            from_state,
    input  logic [1:0]            to_state,
    input  logic [31:0]           time_stamp,
    input  logic                  matrix_done,
    input  logic                  restart,
    output cmd_t                  cmd,
    input  status_t               status,
    output logic [SW-1:0]         w_row,
    output logic [SW-1:0]         w_col,
    output logic [SW-1:0]         p_row,
    output logic [SW-1:0]         p_col,
    output logic [SW-1:0]         q_row,
    output logic [SW-1:0]         q_col,
    output logic [SW-1:0]         d_row,
    output logic [SW-1:0]         d_col
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SUM     = 6'b000010,
        ST_MAC     = 6'b000100,
        ST_DRAIN   = 6'b001000,
        ST_EMIT_RD = 6'b010000,
        ST_EMIT_LD = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    logic [SW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [1:0]    drain_reg, drain_next;
    logic          dir_reg;
    logic [31:0]   pred_reg;
    logic [2:0]    states_reg;
    logic [CW-1:0] n_act;
    logic [SW-1:0] nm1;
    logic          wr_en;
    logic [1:0]    reg_idx;
    logic          accept, write_ok, relevant;
    logic          j_end, k_end, i_end;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg    <= 1'b0;
            pred_reg   <= 32'd0;
            states_reg <= 3'd4;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DIRECTION: dir_reg    <= pwdata[0];
                REG_PRED_TIME: pred_reg   <= pwdata;
                REG_STATES:    states_reg <= pwdata[2:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DIRECTION: prdata = {31'd0, dir_reg};
            REG_PRED_TIME: prdata = pred_reg;
            REG_STATES:    prdata = {29'd0, states_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // active state count clamped to [2, NUM_STATES]
    always_comb
    begin
        if (states_reg < 3'd2)
        begin
            n_act = CW'(2);
        end
        else if (32'(states_reg) > NUM_STATES)
        begin
            n_act = CW'(NUM_STATES);
        end
        else
        begin
            n_act = CW'(states_reg);
        end
    end

    assign nm1 = SW'(n_act - CW'(1));

    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign in_stall = (state_reg != ST_IDLE);
    assign write_ok = (32'(from_state) < 32'(n_act)) && (32'(to_state) < 32'(n_act))
                      && (from_state != to_state);
    assign relevant = dir_reg ? (time_stamp <= pred_reg) : (pred_reg < time_stamp);
    assign w_row    = SW'(from_state);
    assign w_col    = SW'(to_state);

    assign i_end = (i_reg == nm1);
    assign j_end = (j_reg == nm1);
    assign k_end = (k_reg == nm1);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        drain_next = drain_reg;
        cmd        = '0;
        p_row      = i_reg;
        p_col      = k_reg;
        q_row      = i_reg;
        q_col      = j_reg;
        d_row      = i_reg;
        d_col      = j_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.p_clear = restart;
                    cmd.inc_we  = write_ok;
                    if (matrix_done)
                    begin
                        cmd.ts_load = 1'b1;
                        if (relevant)
                        begin
                            state_next = ST_SUM;
                            i_next     = '0;
                            j_next     = '0;
                        end
                        else
                        begin
                            cmd.inc_clear = 1'b1;
                        end
                    end
                end
            end
            ST_SUM:
            begin
                cmd.sum_en    = 1'b1;
                cmd.sum_first = (j_reg == '0);
                cmd.sum_last  = j_end;
                if (j_end)
                begin
                    j_next = '0;
                    i_next = i_reg + SW'(1);
                    if (i_end)
                    begin
                        state_next = ST_MAC;
                        i_next     = '0;
                        k_next     = '0;
                    end
                end
                else
                begin
                    j_next = j_reg + SW'(1);
                end
            end
            ST_MAC:
            begin
                cmd.mac_en    = 1'b1;
                cmd.mac_first = (k_reg == '0);
                cmd.mac_last  = k_end;
                // forward: P[i][k] * Q[k][j], backward: Q[i][k] * P[k][j]
                if (dir_reg)
                begin
                    q_row = i_reg;
                    q_col = k_reg;
                    p_row = k_reg;
                    p_col = j_reg;
                end
                else
                begin
                    p_row = i_reg;
                    p_col = k_reg;
                    q_row = k_reg;
                    q_col = j_reg;
                end
                if (k_end)
                begin
                    k_next = '0;
                    if (j_end)
                    begin
                        j_next = '0;
                        i_next = i_reg + SW'(1);
                        if (i_end)
                        begin
                            cmd.inc_clear = 1'b1;
                            state_next    = ST_DRAIN;
                            drain_next    = 2'd0;
                            i_next        = '0;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + SW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + SW'(1);
                end
            end
            ST_DRAIN:
            begin
                // let the multiply-accumulate pipeline empty into the result ram
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd2)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                cmd.emit_ld   = 1'b1;
                cmd.emit_last = i_end && j_end;
                state_next    = ST_EMIT_RD;
                if (j_end)
                begin
                    j_next = '0;
                    i_next = i_reg + SW'(1);
                    if (i_end)
                    begin
                        state_next = ST_IDLE;
                        i_next     = '0;
                    end
                end
                else
                begin
                    j_next = j_reg + SW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            drain_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// File: sv/tmpi_dp.sv
// datapath: increment, product and result rams, row sums, shared multiply-accumulate,
// output register; depends on tmpi_pkg and tmpi_ram
module tmpi_dp
    import tmpi_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF,
    localparam int SW = $clog2(NUM_STATES),
    localparam int DEPTH = NUM_STATES * NUM_STATES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [SW-1:0]      w_row,
    input  logic [SW-1:0]      w_col,
    input  logic [SW-1:0]      p_row,
    input  logic [SW-1:0]      p_col,
    input  logic [SW-1:0]      q_row,
    input  logic [SW-1:0]      q_col,
    input  logic [SW-1:0]      d_row,
    input  logic [SW-1:0]      d_col,
    input  logic signed [31:0] increment,
    input  logic [31:0]        time_stamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         row_index,
    output logic [1:0]         column_index,
    output logic signed [31:0] probability,
    output logic [31:0]        result_time,
    output logic               last_entry
);

    localparam int SUMW = 32 + SW + 1;
    localparam int ACCW = 64 + SW + 1;
    localparam logic signed [SUMW-1:0] SUM_HI = SUMW'(Q30_MAX);
    localparam logic signed [SUMW-1:0] SUM_LO = SUMW'(Q30_MIN);
    localparam logic signed [ACCW-1:0] ACC_HI = ACCW'(Q30_MAX);
    localparam logic signed [ACCW-1:0] ACC_LO = ACCW'(Q30_MIN);
    localparam logic signed [ACCW-1:0] HALF   = ACCW'(64'sd536870912);

    function automatic logic [AW-1:0] lin(input logic [SW-1:0] r, input logic [SW-1:0] c);
        lin = AW'(32'(r) * NUM_STATES + 32'(c));
    endfunction

    logic [DEPTH-1:0] inc_vld_reg, p_vld_reg;
    logic [31:0]      inc_rdata, p_rdata, nxt_rdata;
    logic [AW-1:0]    q_addr, p_addr, e_addr;

    // stage 1: ram outputs and their tags
    logic          s1_sum, s1_sfirst, s1_slast, s1_mac, s1_mfirst, s1_mlast;
    logic          s1_qdiag, s1_qvld, s1_pdiag, s1_pvld;
    logic [SW-1:0] s1_qrow;
    logic [AW-1:0] s1_dest;
    // stage 2: product
    logic                 s2_mac, s2_first, s2_last;
    logic [AW-1:0]        s2_dest;
    logic signed [63:0]   prod_reg;
    // stage 3: accumulated dot product
    logic signed [ACCW-1:0] acc_reg, acc_tot, fin_reg, fin_rnd, fin_shift;
    logic                   fin_vld;
    logic [AW-1:0]          fin_dest;
    logic signed [31:0]     fin_q;
    // row sums
    logic signed [SUMW-1:0] rs_reg, rs_tot, rs_term, diag_val;
    logic signed [31:0]     diag_reg [NUM_STATES];
    logic signed [31:0]     pv, qv;

    logic          out_vld_reg;
    logic [1:0]    row_reg, col_reg;
    logic signed [31:0] prob_reg;
    logic [31:0]   ts_reg, rt_reg;
    logic          last_reg;

    assign q_addr = lin(q_row, q_col);
    assign p_addr = lin(p_row, p_col);
    assign e_addr = lin(d_row, d_col);

    tmpi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_inc_ram (
        .clk   (clk),
        .we    (cmd.inc_we),
        .waddr (lin(w_row, w_col)),
        .wdata (increment),
        .raddr (q_addr),
        .rdata (inc_rdata)
    );

    tmpi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_prod_ram (
        .clk   (clk),
        .we    (cmd.emit_ld),
        .waddr (e_addr),
        .wdata (nxt_rdata),
        .raddr (p_addr),
        .rdata (p_rdata)
    );

    tmpi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_next_ram (
        .clk   (clk),
        .we    (fin_vld),
        .waddr (fin_dest),
        .wdata (fin_q),
        .raddr (e_addr),
        .rdata (nxt_rdata)
    );

    // valid bits: an invalid increment reads zero, an invalid product entry reads identity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_vld_reg <= '0;
            p_vld_reg   <= '0;
        end
        else
        begin
            if (cmd.inc_clear)
            begin
                inc_vld_reg <= '0;
            end
            else if (cmd.inc_we)
            begin
                inc_vld_reg[lin(w_row, w_col)] <= 1'b1;
            end
            if (cmd.p_clear)
            begin
                p_vld_reg <= '0;
            end
            else if (cmd.emit_ld)
            begin
                p_vld_reg[e_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_sum  <= 1'b0;
            s1_mac  <= 1'b0;
            s2_mac  <= 1'b0;
            fin_vld <= 1'b0;
        end
        else
        begin
            s1_sum  <= cmd.sum_en;
            s1_mac  <= cmd.mac_en;
            s2_mac  <= s1_mac;
            fin_vld <= s2_mac && s2_last;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sfirst <= cmd.sum_first;
        s1_slast  <= cmd.sum_last;
        s1_mfirst <= cmd.mac_first;
        s1_mlast  <= cmd.mac_last;
        s1_qdiag  <= (q_row == q_col);
        s1_qvld   <= inc_vld_reg[q_addr];
        s1_pdiag  <= (p_row == p_col);
        s1_pvld   <= p_vld_reg[p_addr];
        s1_qrow   <= q_row;
        s1_dest   <= e_addr;
    end

    // diagonal of the increment matrix: 1.0 minus the off-diagonal row sum
    assign rs_term  = (s1_qvld && !s1_qdiag) ? SUMW'($signed(inc_rdata)) : '0;
    assign rs_tot   = (s1_sfirst ? '0 : rs_reg) + rs_term;
    assign diag_val = SUMW'(ONE_Q30) - rs_tot;

    always_ff @(posedge clk)
    begin
        if (s1_sum)
        begin
            rs_reg <= rs_tot;
            if (s1_slast)
            begin
                if (diag_val > SUM_HI)
                begin
                    diag_reg[s1_qrow] <= Q30_MAX;
                end
                else if (diag_val < SUM_LO)
                begin
                    diag_reg[s1_qrow] <= Q30_MIN;
                end
                else
                begin
                    diag_reg[s1_qrow] <= 32'(diag_val);
                end
            end
        end
    end

    assign pv = s1_pvld ? $signed(p_rdata) : (s1_pdiag ? ONE_Q30 : 32'sd0);
    assign qv = s1_qdiag ? diag_reg[s1_qrow] : (s1_qvld ? $signed(inc_rdata) : 32'sd0);

    always_ff @(posedge clk)
    begin
        prod_reg <= pv * qv;
        s2_first <= s1_mfirst;
        s2_last  <= s1_mlast;
        s2_dest  <= s1_dest;
    end

    assign acc_tot = (s2_first ? '0 : acc_reg) + ACCW'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (s2_mac)
        begin
            acc_reg <= acc_tot;
        end
        fin_reg  <= acc_tot;
        fin_dest <= s2_dest;
    end

    // round half up from Q4.60 to Q2.30, then saturate
    assign fin_rnd   = fin_reg + HALF;
    assign fin_shift = fin_rnd >>> 30;
    assign fin_q     = (fin_shift > ACC_HI) ? Q30_MAX :
                       (fin_shift < ACC_LO) ? Q30_MIN : 32'(fin_shift);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.emit_ld)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ts_load)
        begin
            ts_reg <= time_stamp;
        end
        if (cmd.emit_ld)
        begin
            row_reg  <= 2'(d_row);
            col_reg  <= 2'(d_col);
            prob_reg <= $signed(nxt_rdata);
            rt_reg   <= ts_reg;
            last_reg <= cmd.emit_last;
        end
    end

    assign status.out_free = !out_vld_reg || !out_stall;
    assign out_valid       = out_vld_reg;
    assign row_index       = row_reg;
    assign column_index    = col_reg;
    assign probability     = prob_reg;
    assign result_time     = rt_reg;
    assign last_entry      = last_reg;

endmodule

// File: sv/transition_matrix_product_integral_unit.sv
// top level of the transition matrix product unit
// depends on tmpi_pkg, tmpi_ctrl, tmpi_dp (and tmpi_ram through the datapath)
//
// Takes off-diagonal hazard increments one request per cycle while in_stall is low;
// an element that does not close its matrix leaves the input free for the next. A
// closing element whose time stamp is relevant keeps the input stalled through the row
// sums, the products through the single shared multiply-accumulate (one term a cycle),
// the pipeline drain and the emission of n*n entries, each read and then loaded into
// the output register once it is free. An irrelevant closing element does not stall
// the input and emits nothing. The product and increment stores are rams whose reset and
// clear state is held in per-entry valid bits, so there is no clearing pass after reset.
module transition_matrix_product_integral_unit
    import tmpi_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF,
    localparam int SW = $clog2(NUM_STATES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            from_state,
    input  logic [1:0]            to_state,
    input  logic signed [31:0]    increment,
    input  logic [31:0]           time_stamp,
    input  logic                  matrix_done,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            row_index,
    output logic [1:0]            column_index,
    output logic signed [31:0]    probability,
    output logic [31:0]           result_time,
    output logic                  last_entry
);

    cmd_t          cmd;
    status_t       status;
    logic [SW-1:0] w_row, w_col, p_row, p_col, q_row, q_col, d_row, d_col;

    assign pready = 1'b1;

    tmpi_ctrl #(.NUM_STATES(NUM_STATES)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .from_state  (from_state),
        .to_state    (to_state),
        .time_stamp  (time_stamp),
        .matrix_done (matrix_done),
        .restart     (restart),
        .cmd         (cmd),
        .status      (status),
        .w_row       (w_row),
        .w_col       (w_col),
        .p_row       (p_row),
        .p_col       (p_col),
        .q_row       (q_row),
        .q_col       (q_col),
        .d_row       (d_row),
        .d_col       (d_col)
    );

    tmpi_dp #(.NUM_STATES(NUM_STATES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .w_row        (w_row),
        .w_col        (w_col),
        .p_row        (p_row),
        .p_col        (p_col),
        .q_row        (q_row),
        .q_col        (q_col),
        .d_row        (d_row),
        .d_col        (d_col),
        .increment    (increment),
        .time_stamp   (time_stamp),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_index    (row_index),
        .column_index (column_index),
        .probability  (probability),
        .result_time  (result_time),
        .last_entry   (last_entry)
    );

endmodule

// File: tb/tmpi_result_checker.sv
// result checker for the transition matrix product unit: tracks the register port and the
// accepted requests, predicts every emitted product entry and compares it
// depends on tmpi_pkg
module tmpi_result_checker
    import tmpi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            from_state,
    input  logic [1:0]            to_state,
    input  logic signed [31:0]    increment,
    input  logic [31:0]           time_stamp,
    input  logic                  matrix_done,
    input  logic                  restart,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [1:0]            row_index,
    input  logic [1:0]            column_index,
    input  logic signed [31:0]    probability,
    input  logic [31:0]           result_time,
    input  logic                  last_entry,
    output int                    fail_count,
    output int                    entries_pending
);

    localparam int NS = NUM_STATES_DEF;

    typedef struct packed {
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] prob;
        logic [31:0]        stamp;
        logic               last;
    } entry_t;

    entry_t             expected_entries[$];
    logic               backward_mode;
    logic [31:0]        horizon;
    logic [2:0]         state_count;
    logic signed [31:0] product[NS][NS];
    logic signed [31:0] hazard[NS][NS];

    assign entries_pending = expected_entries.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic logic signed [31:0] clip_q30(input logic signed [127:0] v);
        if (v > 128'sh7fff_ffff)
            return Q30_MAX;
        if (v < -128'sh8000_0000)
            return Q30_MIN;
        return v[31:0];
    endfunction

    task automatic set_identity();
        for (int i = 0; i < NS; i++)
            for (int j = 0; j < NS; j++)
                product[i][j] = (i == j) ? ONE_Q30 : 32'sd0;
    endtask

    task automatic absorb_element();
        int                  n;
        logic signed [31:0]  q[NS][NS];
        logic signed [31:0]  nxt[NS][NS];
        logic signed [127:0] acc;
        logic                relevant;
        entry_t              e;
        n = (state_count < 2) ? 2 : (state_count > NS) ? NS : int'(state_count);
        if (restart)
            set_identity();
        if (from_state < n && to_state < n && from_state != to_state)
            hazard[from_state][to_state] = increment;
        if (!matrix_done)
            return;
        for (int i = 0; i < n; i++)
        begin
            acc = 0;
            for (int j = 0; j < n; j++)
            begin
                q[i][j] = hazard[i][j];
                if (j != i)
                    acc += hazard[i][j];
            end
            q[i][i] = clip_q30(128'(ONE_Q30) - acc);
        end
        for (int i = 0; i < NS; i++)
            for (int j = 0; j < NS; j++)
                hazard[i][j] = 0;
        relevant = backward_mode ? (time_stamp <= horizon) : (horizon < time_stamp);
        if (!relevant)
            return;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc += backward_mode ? 128'(q[i][k]) * 128'(product[k][j])
                                         : 128'(product[i][k]) * 128'(q[k][j]);
                // round half up from Q4.60 to Q2.30
                nxt[i][j] = clip_q30((acc + 128'sd536870912) >>> 30);
            end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                product[i][j] = nxt[i][j];
                e.row   = i[1:0];
                e.col   = j[1:0];
                e.prob  = nxt[i][j];
                e.stamp = time_stamp;
                e.last  = (i == n - 1 && j == n - 1);
                expected_entries.insert(expected_entries.size(), e);
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        entry_t e;
        if (!rst_n)
        begin
            fail_count    = 0;
            backward_mode = 1'b0;
            horizon       = '0;
            state_count   = 3'd4;
            set_identity();
            for (int i = 0; i < NS; i++)
                for (int j = 0; j < NS; j++)
                    hazard[i][j] = 0;
            expected_entries.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_DIRECTION: backward_mode = pwdata[0];
                    REG_PRED_TIME: horizon = pwdata;
                    REG_STATES:    state_count = pwdata[2:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                absorb_element();
            if (out_valid && !out_stall)
            begin
                if (expected_entries.size() == 0)
                    report("unexpected entry", {row_index, column_index}, 0);
                else
                begin
                    e = expected_entries.pop_front();
                    if (row_index != e.row)
                        report("row_index", row_index, e.row);
                    if (column_index != e.col)
                        report("column_index", column_index, e.col);
                    if (probability != e.prob)
                        report("probability", probability, e.prob);
                    if (result_time != e.stamp)
                        report("result_time", result_time, e.stamp);
                    if (last_entry != e.last)
                        report("last_entry", last_entry, e.last);
                end
            end
        end
    end

endmodule

// File: tb/tb_transition_matrix_product_integral_unit.sv
// testbench top for the transition matrix product unit: clock, reset, register writes,
// increment requests with bursts and gaps, output stalls and the verdict
// depends on tmpi_pkg, tmpi_result_checker and transition_matrix_product_integral_unit
module tb_transition_matrix_product_integral_unit;
    import tmpi_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            from_state;
    logic [1:0]            to_state;
    logic signed [31:0]    increment;
    logic [31:0]           time_stamp;
    logic                  matrix_done;
    logic                  restart;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            row_index;
    logic [1:0]            column_index;
    logic signed [31:0]    probability;
    logic [31:0]           result_time;
    logic                  last_entry;
    int                    fail_count;
    int                    entries_pending;

    int                    burst_left;
    int                    hold_cycles;
    int                    idle_cycles;
    logic [31:0]           horizon;
    int                    active_n;

    transition_matrix_product_integral_unit dut (.*);

    tmpi_result_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: changes its stall pattern after a random span, or holds off on request
    initial
    begin
        int mode;
        int span;
        out_stall = 1'b0;
        hold_cycles = 0;
        mode = 0;
        span = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(10, 80);
                end
                span--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    2: out_stall <= ($urandom_range(0, 9) != 0);
                    default: out_stall <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no accepted request or entry
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("tb_transition_matrix_product_integral_unit NOT OK");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic dir, input logic [31:0] pt, input logic [2:0] cnt);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (entries_pending == 0);
        repeat (150) @(posedge clk);
        write_reg(REG_DIRECTION, {31'd0, dir});
        write_reg(REG_PRED_TIME, pt);
        write_reg(REG_STATES, {29'd0, cnt});
        horizon  = pt;
        active_n = (cnt < 2) ? 2 : (cnt > 4) ? 4 : cnt;
    endtask

    task automatic put_request(input logic [1:0] r, input logic [1:0] c,
                               input logic [31:0] inc, input logic [31:0] ts,
                               input logic done, input logic rs);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        from_state  <= r;
        to_state    <= c;
        increment   <= inc;
        time_stamp  <= ts;
        matrix_done <= done;
        restart     <= rs;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_increment();
        case ($urandom_range(0, 11))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            4: return -$urandom_range(0, 32'h0400_0000);
            default: return $urandom_range(0, 32'h0800_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_stamp();
        logic [31:0] t;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return horizon;
            default:
            begin
                t = horizon + $urandom_range(0, 2000) - 1000;
                return t;
            end
        endcase
    endfunction

    // one time point: a few elements, mostly in the active corner, the last one closes the matrix
    task automatic send_matrix();
        int          cnt;
        logic [31:0] ts;
        logic        rs;
        logic [1:0]  r;
        logic [1:0]  c;
        ts  = pick_stamp();
        cnt = $urandom_range(1, active_n * (active_n - 1) + 1);
        rs  = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < cnt; k++)
        begin
            r = $urandom_range(0, 3);
            c = $urandom_range(0, 3);
            if ($urandom_range(0, 4) != 0)
            begin
                r = $urandom_range(0, active_n - 1);
                c = $urandom_range(0, active_n - 1);
            end
            put_request(r, c, pick_increment(), ts, k == cnt - 1, rs && k == 0);
        end
    endtask

    initial
    begin
        int sent;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        from_state  = '0;
        to_state    = '0;
        increment   = '0;
        time_stamp  = '0;
        matrix_done = 1'b0;
        restart     = 1'b0;
        burst_left  = 0;
        horizon     = 0;
        active_n    = 4;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, forward, everything after time zero is relevant
        put_request(2'd0, 2'd1, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, 1'b0);
        put_request(2'd0, 2'd2, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, 1'b0);
        put_request(2'd1, 2'd0, 32'h8000_0000, 32'hffff_ffff, 1'b0, 1'b0);
        put_request(2'd2, 2'd2, 32'h1234_5678, 32'hffff_ffff, 1'b0, 1'b0);
        put_request(2'd3, 2'd0, 32'h0100_0000, 32'hffff_ffff, 1'b0, 1'b0);
        put_request(2'd3, 2'd0, 32'h0200_0000, 32'hffff_ffff, 1'b1, 1'b0);
        put_request(2'd1, 2'd2, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0);
        put_request(2'd0, 2'd3, 32'h0800_0000, 32'h0000_0000, 1'b1, 1'b0);
        put_request(2'd2, 2'd1, 32'h0400_0000, 32'h0000_0005, 1'b1, 1'b1);
        // restart on an element that does not close
        put_request(2'd1, 2'd3, 32'h0080_0000, 32'h0000_0006, 1'b0, 1'b1);
        put_request(2'd3, 2'd1, 32'hffc0_0000, 32'h0000_0006, 1'b1, 1'b0);

        // fixed horizon, two states, indices beyond the active corner
        configure(1'b1, 32'hffff_ffff, 3'd2);
        put_request(2'd0, 2'd1, 32'h1000_0000, 32'hffff_ffff, 1'b0, 1'b1);
        put_request(2'd3, 2'd2, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, 1'b0);
        put_request(2'd1, 2'd0, 32'h0800_0000, 32'hffff_ffff, 1'b1, 1'b0);
        put_request(2'd0, 2'd3, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0);

        // state counts out of range, time zero horizon in fixed-horizon mode
        configure(1'b1, 32'h0000_0000, 3'd0);
        put_request(2'd1, 2'd0, 32'h2000_0000, 32'h0000_0000, 1'b1, 1'b0);
        put_request(2'd1, 2'd0, 32'h2000_0000, 32'h0000_0001, 1'b1, 1'b0);
        configure(1'b0, 32'h0000_0400, 3'd7);
        put_request(2'd2, 2'd3, 32'h0200_0000, 32'h0000_0400, 1'b1, 1'b0);
        put_request(2'd3, 2'd2, 32'h0200_0000, 32'h0000_0401, 1'b1, 1'b0);

        // random phases over several settings
        sent = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: configure(1'b0, 32'd1000, 3'd4);
                1: configure(1'b1, 32'd1000, 3'd3);
                2: configure(1'b0, 32'd50000, 3'd2);
                3: configure(1'b1, 32'hffff_fc00, 3'd4);
                4: configure(1'b0, $urandom(), 3'd1);
                5: configure(1'b1, $urandom(), 3'd6);
                6: configure(1'b0, 32'hffff_ffff, 3'd3);
                default: configure(1'b0, 32'd0, 3'd5);
            endcase
            if (ph == 2)
                hold_cycles = 700;
            for (int m = 0; m < 10; m++)
            begin
                send_matrix();
                // in phase 3, let every outstanding entry drain before the last matrix
                if (ph == 3 && m == 8)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    wait (entries_pending == 0);
                    @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (entries_pending == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb_transition_matrix_product_integral_unit OK");
        else
            $display("tb_transition_matrix_product_integral_unit NOT OK");
        $finish;
    end

endmodule
